/* src/gdad_pkg.sv */
package gdad_pkg;

  localparam int ADD_DAYS_BITS = 12;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 16;
  localparam int ADD_W  = 12;
  // day plus count before normalizing
  localparam int DSUM_W = ADD_W + 1;
  // year mod 400
  localparam int R400_W = 9;
  // year / 400
  localparam int Q_W    = 8;

  // floor(2^24 / 400); quotient may come out one low, fixed by one subtract
  localparam logic [15:0] RECIP_400   = 16'd41943;
  localparam int          RECIP_SHIFT = 24;
  localparam logic [9:0]  YEARS_400   = 10'd400;

  localparam logic [R400_W-1:0] R400_LAST = 9'd399;
  localparam logic [R400_W-1:0] R400_100  = 9'd100;
  localparam logic [R400_W-1:0] R400_200  = 9'd200;
  localparam logic [R400_W-1:0] R400_300  = 9'd300;

  localparam logic [YEAR_W-1:0] YEAR_MAX = 16'hFFFF;

  localparam logic [MON_W-1:0] MON_NONE = 4'd0;
  localparam logic [MON_W-1:0] MON_JAN  = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB  = 4'd2;
  localparam logic [MON_W-1:0] MON_APR  = 4'd4;
  localparam logic [MON_W-1:0] MON_JUN  = 4'd6;
  localparam logic [MON_W-1:0] MON_SEP  = 4'd9;
  localparam logic [MON_W-1:0] MON_NOV  = 4'd11;
  localparam logic [MON_W-1:0] MON_DEC  = 4'd12;

  localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
  localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;
  localparam logic [DAY_W-1:0] LEN_FEB   = 5'd28;
  localparam logic [DAY_W-1:0] LEN_FEB_L = 5'd29;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [DSUM_W-1:0] day_sum;
    logic [MON_W-1:0]  mon;
    logic [YEAR_W-1:0] year;
    logic [R400_W-1:0] r400;
  } gdad_job_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } gdad_bk_state_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mon,
                                                input logic leap);
    logic [DAY_W-1:0] len;
    case (mon) inside
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_SHORT;
      MON_FEB: len = leap ? LEN_FEB_L : LEN_FEB;
      default: len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

/* src/gdad_if.sv */
interface gdad_in_if;
  import gdad_pkg::*;
  logic              valid;
  logic              ready;
  logic [DAY_W-1:0]  start_day;
  logic [MON_W-1:0]  start_month;
  logic [YEAR_W-1:0] start_year;
  logic [ADD_W-1:0]  days_to_add;

  modport source (output valid, start_day, start_month, start_year, days_to_add,
                  input ready);
  modport sink (input valid, start_day, start_month, start_year, days_to_add,
                output ready);
endinterface

interface gdad_out_if;
  import gdad_pkg::*;
  logic              valid;
  logic              ready;
  logic [DAY_W-1:0]  new_day;
  logic [MON_W-1:0]  new_month;
  logic [YEAR_W-1:0] new_year;
  logic              year_overflow;

  modport source (output valid, new_day, new_month, new_year, year_overflow,
                  input ready);
  modport sink (input valid, new_day, new_month, new_year, year_overflow,
                output ready);
endinterface

/* src/gdad_front.sv */
module gdad_front (
  input  logic                clk,
  input  logic                rst_n,
  gdad_in_if.sink             in_word,
  output gdad_pkg::gdad_job_t job,
  output logic                job_valid,
  input  logic                job_ready
);
  import gdad_pkg::*;

  logic                     s1_valid_r;
  logic [DSUM_W-1:0]        s1_day_r;
  logic [MON_W-1:0]         s1_mon_r;
  logic [YEAR_W-1:0]        s1_year_r;
  logic [Q_W-1:0]           s1_q_r;
  logic [MON_W-1:0]         mon_clamp;
  logic [YEAR_W+15:0]       prod;
  logic [YEAR_W-1:0]        q_times_400;
  logic [YEAR_W-1:0]        rem_wide;
  logic [9:0]               rem;
  logic [9:0]               rem_fix;
  logic                     accept;

  assign accept = in_word.valid && in_word.ready;
  assign in_word.ready = !s1_valid_r || job_ready;
  assign job_valid = s1_valid_r;

  always_comb begin
    if (in_word.start_month == MON_NONE) begin
      mon_clamp = MON_JAN;
    end else if (in_word.start_month > MON_DEC) begin
      mon_clamp = MON_DEC;
    end else begin
      mon_clamp = in_word.start_month;
    end
  end

  assign prod = (YEAR_W + 16)'(in_word.start_year) * (YEAR_W + 16)'(RECIP_400);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_word.ready) begin
      s1_valid_r <= in_word.valid;
    end
    if (accept) begin
      s1_day_r  <= DSUM_W'(in_word.start_day)
                 + DSUM_W'(in_word.days_to_add[ADD_DAYS_BITS-1:0]);
      s1_mon_r  <= mon_clamp;
      s1_year_r <= in_word.start_year;
      s1_q_r    <= prod[RECIP_SHIFT +: Q_W];
    end
  end

  // q*400 = q*256 + q*128 + q*16
  assign q_times_400 = (YEAR_W'(s1_q_r) << 8) + (YEAR_W'(s1_q_r) << 7)
                     + (YEAR_W'(s1_q_r) << 4);
  assign rem_wide = s1_year_r - q_times_400;
  assign rem      = rem_wide[9:0];
  assign rem_fix  = (rem >= YEARS_400) ? (rem - YEARS_400) : rem;

  always_comb begin
    job.day_sum = s1_day_r;
    job.mon     = s1_mon_r;
    job.year    = s1_year_r;
    job.r400    = rem_fix[R400_W-1:0];
  end

endmodule

/* src/gdad_fifo.sv */
module gdad_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gdad_pkg::gdad_job_t push_data,
  output logic                full,
  input  logic                pop,
  output gdad_pkg::gdad_job_t pop_data,
  output logic                empty
);
  import gdad_pkg::*;

  gdad_job_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [FIFO_CNT_W-1:0]   count_r;
  logic [FIFO_CNT_W-1:0]   count_nxt;

  assign full     = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/gdad_back.sv */
module gdad_back (
  input  logic                clk,
  input  logic                rst_n,
  input  gdad_pkg::gdad_job_t job,
  input  logic                job_valid,
  output logic                job_ready,
  gdad_out_if.source          out_word
);
  import gdad_pkg::*;

  gdad_bk_state_t     state_r, state_nxt;
  logic [DSUM_W-1:0]  day_r, day_nxt;
  logic [MON_W-1:0]   mon_r, mon_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [R400_W-1:0]  r400_r, r400_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DAY_W-1:0]   out_day_r, out_day_nxt;
  logic [MON_W-1:0]   out_mon_r, out_mon_nxt;
  logic [YEAR_W-1:0]  out_year_r, out_year_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic               leap;
  logic [DAY_W-1:0]   len;
  logic               step;
  logic               out_free;

  assign leap = (year_r[1:0] == 2'b00)
             && !(r400_r == R400_100 || r400_r == R400_200 || r400_r == R400_300);
  assign len      = month_len(mon_r, leap);
  assign step     = day_r > DSUM_W'(len);
  assign out_free = !out_valid_r || out_word.ready;

  always_comb begin
    state_nxt     = state_r;
    day_nxt       = day_r;
    mon_nxt       = mon_r;
    year_nxt      = year_r;
    r400_nxt      = r400_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_word.ready;
    out_day_nxt   = out_day_r;
    out_mon_nxt   = out_mon_r;
    out_year_nxt  = out_year_r;
    out_ovf_nxt   = out_ovf_r;
    job_ready     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          day_nxt   = job.day_sum;
          mon_nxt   = job.mon;
          year_nxt  = job.year;
          r400_nxt  = job.r400;
          ovf_nxt   = 1'b0;
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (step) begin
          // cross one month end
          day_nxt = day_r - DSUM_W'(len);
          if (mon_r == MON_DEC) begin
            mon_nxt = MON_JAN;
            if (year_r == YEAR_MAX) begin
              year_nxt = '0;
              r400_nxt = '0;
              ovf_nxt  = 1'b1;
            end else begin
              year_nxt = year_r + 1'b1;
              r400_nxt = (r400_r == R400_LAST) ? '0 : r400_r + 1'b1;
            end
          end else begin
            mon_nxt = mon_r + 1'b1;
          end
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_day_nxt   = day_r[DAY_W-1:0];
          out_mon_nxt   = mon_r;
          out_year_nxt  = year_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    day_r      <= day_nxt;
    mon_r      <= mon_nxt;
    year_r     <= year_nxt;
    r400_r     <= r400_nxt;
    ovf_r      <= ovf_nxt;
    out_day_r  <= out_day_nxt;
    out_mon_r  <= out_mon_nxt;
    out_year_r <= out_year_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_word.valid         = out_valid_r;
  assign out_word.new_day       = out_day_r;
  assign out_word.new_month     = out_mon_r;
  assign out_word.new_year      = out_year_r;
  assign out_word.year_overflow = out_ovf_r;

endmodule

/* src/gregorian_date_add_days_unit.sv */
// Adds a day count to a Gregorian date and returns the normalized date, one
// result word per input word. The front stage registers the word, clamps the
// month to 1..12, adds the count to the day and reduces the year mod 400;
// a two-entry queue then feeds the normalizer, which crosses one month end
// per clock. Each item passes through the front register and the queue to
// the normalizer, which steps once for each month crossed (up to about 140
// for the largest count); the normalizer handles one item at a time and sets
// the rate, while the front keeps accepting until the queue fills. Year 65535
// rolls over to 0 and raises year_overflow.
module gregorian_date_add_days_unit (
  input  logic       clk,
  input  logic       rst_n,
  gdad_in_if.sink    in_word,
  gdad_out_if.source out_word
);
  import gdad_pkg::*;

  gdad_job_t front_job;
  gdad_job_t back_job;
  logic      front_valid;
  logic      fifo_full;
  logic      fifo_empty;
  logic      fifo_push;
  logic      fifo_pop;
  logic      back_ready;

  assign fifo_push = front_valid && !fifo_full;
  assign fifo_pop  = back_ready && !fifo_empty;

  gdad_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (!fifo_full)
  );

  gdad_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_data (front_job),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .pop_data  (back_job),
    .empty     (fifo_empty)
  );

  gdad_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (back_job),
    .job_valid (!fifo_empty),
    .job_ready (back_ready),
    .out_word  (out_word)
  );

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid |-> (out_word.new_month >= MON_JAN && out_word.new_month <= MON_DEC))
    else $error("result month out of range");

  // a wrap can be followed by at most a dozen more years
  a_ovf_year: assert property (@(posedge clk) disable iff (!rst_n)
    (out_word.valid && out_word.year_overflow) |-> (out_word.new_year <= 16'd12))
    else $error("overflow with large year");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |=> !fifo_pop)
    else $error("normalizer took two words back to back");

endmodule

/* verif/tb_gregorian_date_add_days_unit.sv */
`timescale 1ns / 100ps

module tb_gregorian_date_add_days_unit;
  import gdad_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  mon;
    logic [YEAR_W-1:0] year;
    logic              ovf;
  } date_word_t;

  logic clk;
  logic rst_n;
  int   errors;
  int   cycle_count;
  bit   idle_on;

  date_word_t pending_dates[$];

  gdad_in_if  in_if();
  gdad_out_if out_if();

  gregorian_date_add_days_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_if),
    .out_word (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL gregorian_date_add_days_unit");
    $finish;
  end

  function automatic bit leap_year(int unsigned year);
    bit leap;
    if (year % 4 != 0) leap = 1'b0;
    else if (year % 100 != 0) leap = 1'b1;
    else leap = (year % 400 == 0);
    return leap;
  endfunction

  function automatic int unsigned days_of(int unsigned mon, int unsigned year);
    int unsigned len;
    case (mon)
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 32'(LEN_SHORT);
      MON_FEB: len = 32'(leap_year(year) ? LEN_FEB_L : LEN_FEB);
      default: len = 32'(LEN_LONG);
    endcase
    return len;
  endfunction

  function automatic date_word_t advance_date(logic [DAY_W-1:0] d, logic [MON_W-1:0] m,
                                              logic [YEAR_W-1:0] y, logic [ADD_W-1:0] a);
    int unsigned day;
    int unsigned mon;
    int unsigned year;
    bit          ovf;
    date_word_t  r;
    day  = 32'(d) + 32'(a[ADD_DAYS_BITS-1:0]);
    mon  = 32'(m);
    year = 32'(y);
    ovf  = 1'b0;
    if (mon == MON_NONE) mon = MON_JAN;
    if (mon > MON_DEC) mon = MON_DEC;
    while (day > days_of(mon, year)) begin
      day -= days_of(mon, year);
      mon++;
      if (mon > MON_DEC) begin
        mon = MON_JAN;
        if (year == YEAR_MAX) begin
          year = 0;
          ovf  = 1'b1;
        end else begin
          year++;
        end
      end
    end
    r.day  = DAY_W'(day);
    r.mon  = MON_W'(mon);
    r.year = YEAR_W'(year);
    r.ovf  = ovf;
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  // called and returns at a falling edge
  task automatic send_date(logic [DAY_W-1:0] d, logic [MON_W-1:0] m,
                           logic [YEAR_W-1:0] y, logic [ADD_W-1:0] a);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.start_day   <= d;
    in_if.start_month <= m;
    in_if.start_year  <= y;
    in_if.days_to_add <= a;
    do @(posedge clk); while (!in_if.ready);
    pending_dates.push_back(advance_date(d, m, y, a));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [YEAR_W-1:0] pick_year();
    logic [YEAR_W-1:0] y;
    case ($urandom_range(0, 5))
      0: y = YEAR_W'($urandom_range(0, 65535));
      1: y = YEAR_W'($urandom_range(65500, 65535));
      2: y = YEAR_W'($urandom_range(0, 655) * 100);
      3: y = YEAR_W'($urandom_range(0, 163) * 400 + $urandom_range(0, 3));
      4: y = YEAR_W'($urandom_range(1900, 2200));
      default: y = YEAR_W'($urandom_range(0, 10));
    endcase
    return y;
  endfunction

  function automatic logic [ADD_W-1:0] pick_count();
    logic [ADD_W-1:0] a;
    case ($urandom_range(0, 9))
      0, 1, 2: a = ADD_W'($urandom_range(0, 4095));
      3: a = ADD_W'($urandom_range(0, 3));
      default: a = ADD_W'($urandom_range(0, 400));
    endcase
    return a;
  endfunction

  task automatic test_directed_edges();
    send_date(5'd1,  MON_JAN, 16'd2024, 12'd0);
    send_date(5'd31, MON_DEC, YEAR_MAX, 12'd1);
    send_date(5'd31, MON_DEC, YEAR_MAX, 12'd4095);
    send_date(5'd1,  4'd3,    YEAR_MAX, 12'd4095);
    send_date(5'd0,  MON_JAN, 16'd2000, 12'd0);
    send_date(5'd0,  MON_JAN, 16'd2000, 12'd1);
    send_date(5'd15, MON_NONE, 16'd2023, 12'd20);
    send_date(5'd20, 4'd13,   16'd2023, 12'd15);
    send_date(5'd31, 4'd15,   YEAR_MAX, 12'd4095);
    send_date(5'd31, 4'd15,   YEAR_MAX, 12'd0);
    send_date(5'd28, MON_FEB, 16'd2000, 12'd1);
    send_date(5'd28, MON_FEB, 16'd1900, 12'd1);
    send_date(5'd28, MON_FEB, 16'd2024, 12'd1);
    send_date(5'd28, MON_FEB, 16'd2023, 12'd1);
    send_date(5'd28, MON_FEB, 16'd0,    12'd1);
    send_date(5'd31, MON_FEB, 16'd2023, 12'd0);
    send_date(5'd31, MON_APR, 16'd2023, 12'd0);
    send_date(5'd31, MON_NOV, 16'd1999, 12'd4095);
    send_date(5'd1,  MON_JAN, 16'd0,    12'd4095);
    send_date(5'd31, MON_DEC, 16'd2099, 12'd1);
    send_date(5'd30, MON_JAN, 16'd2100, 12'd30);
    send_date(5'd31, 4'd15,   16'd0,    12'd4095);
  endtask

  task automatic test_random_dates(int count);
    logic [MON_W-1:0]  m;
    logic [YEAR_W-1:0] y;
    for (int i = 0; i < count; i++) begin
      m = MON_W'($urandom_range(MON_JAN, MON_DEC));
      y = pick_year();
      send_date(DAY_W'($urandom_range(1, days_of(32'(m), 32'(y)))), m, y, pick_count());
      if (i == count / 2) wait_drained();
    end
  endtask

  task automatic test_random_raw(int count);
    for (int i = 0; i < count; i++)
      send_date(DAY_W'($urandom_range(0, 31)), MON_W'($urandom_range(0, 15)),
                YEAR_W'($urandom_range(0, 65535)), ADD_W'($urandom_range(0, 4095)));
  endtask

  task automatic test_year_rollover(int count);
    logic [MON_W-1:0] m;
    for (int i = 0; i < count; i++) begin
      m = MON_W'($urandom_range(0, 15));
      send_date(DAY_W'($urandom_range(0, 31)), m, YEAR_W'($urandom_range(65530, 65535)),
                ADD_W'($urandom_range(0, 4095)));
    end
  endtask

  task automatic test_back_to_back(int count);
    logic [MON_W-1:0]  m;
    logic [YEAR_W-1:0] y;
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      m = MON_W'($urandom_range(MON_JAN, MON_DEC));
      y = pick_year();
      send_date(DAY_W'($urandom_range(1, days_of(32'(m), 32'(y)))), m, y,
                ADD_W'($urandom_range(0, 60)));
    end
  endtask

  initial begin
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    date_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_dates.size() == 0) begin
        $display("[%0t] result word with nothing pending", $time);
        errors++;
      end else begin
        want = pending_dates.pop_front();
        if (out_if.new_day !== want.day)
          report_mismatch("new_day", int'(out_if.new_day), int'(want.day));
        if (out_if.new_month !== want.mon)
          report_mismatch("new_month", int'(out_if.new_month), int'(want.mon));
        if (out_if.new_year !== want.year)
          report_mismatch("new_year", int'(out_if.new_year), int'(want.year));
        if (out_if.year_overflow !== want.ovf)
          report_mismatch("year_overflow", int'(out_if.year_overflow), int'(want.ovf));
      end
    end
  end

  initial begin
    errors            = 0;
    idle_on           = 1'b1;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.start_day   = '0;
    in_if.start_month = '0;
    in_if.start_year  = '0;
    in_if.days_to_add = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_edges();
    wait_drained();
    test_random_dates(600);
    test_random_raw(300);
    test_year_rollover(50);
    test_back_to_back(100);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS gregorian_date_add_days_unit");
    end else begin
      $display("FAIL gregorian_date_add_days_unit");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/gdad_pkg.sv
src/gdad_if.sv
src/gdad_front.sv
src/gdad_fifo.sv
src/gdad_back.sv
src/gregorian_date_add_days_unit.sv
verif/tb_gregorian_date_add_days_unit.sv
